@@ rtl/rf_pulse_frame_decoder_core_defines.svh @@
// assertion helpers shared by the queue and back-end rtl files
`ifndef RF_PULSE_FRAME_DECODER_CORE_DEFINES_SVH
`define RF_PULSE_FRAME_DECODER_CORE_DEFINES_SVH

// condition must hold at every clock edge out of reset
`define RFPD_ASSERT_ALWAYS(lbl, clk, rst_n, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error(msg);

// antecedent in one cycle implies consequent in the next
`define RFPD_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ rtl/rfpd_pkg.sv @@
package rfpd_pkg;

    localparam logic [7:0] FRAME_PULSES = 8'd116;
    localparam logic [7:0] INDEX_MAX    = 8'd255;
    localparam logic [7:0] ADDR_FIRST   = 8'd23;
    localparam logic [7:0] ADDR_LAST    = 8'd86;
    localparam logic [7:0] CMD_FIRST    = 8'd87;
    localparam logic [7:0] CMD_LAST     = 8'd114;

    localparam logic [7:0]  THRESH_RESET = 8'd10;
    localparam logic [1:0]  CMD_OFF      = 2'd1;
    localparam logic [27:0] ADDR_MASK    = 28'hFFF_FFCF;
    localparam int          ON_BIT       = 4;

    localparam int QUEUE_DEPTH_DEF = 4;

    typedef struct packed {
        logic [7:0] pulse_len;
        logic       frame_end;
    } in_item_t;

    typedef struct packed {
        logic        recognized;
        logic        switch_on;
        logic [27:0] device_address;
    } out_item_t;

    // classified pulse handed from front to back
    typedef struct packed {
        logic data_bit;
        logic shift_addr;
        logic shift_cmd;
        logic last;
        logic recognized;
    } q_entry_t;

endpackage

@@ rtl/rfpd_front.sv @@
module rfpd_front
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_wr,
    input  logic [7:0]         cfg_data,
    input  logic               accept,
    input  rfpd_pkg::in_item_t item,
    output rfpd_pkg::q_entry_t entry
);
    import rfpd_pkg::*;

    logic [7:0] thresh_reg;
    logic [7:0] index_reg;
    logic [7:0] index_next;
    logic [7:0] held_reg;
    logic [7:0] held_next;
    logic [7:0] count;
    logic [7:0] first;
    logic       even;

    always_comb
    begin
        // pulse number of this item, saturating
        count = (index_reg != INDEX_MAX) ? index_reg + 8'd1 : INDEX_MAX;
        first = count - 8'd1;
        even  = ~count[0];

        entry.data_bit   = (held_reg < thresh_reg) && (item.pulse_len > thresh_reg);
        entry.shift_addr = even && (first inside {[ADDR_FIRST:ADDR_LAST]});
        entry.shift_cmd  = even && (first inside {[CMD_FIRST:CMD_LAST]});
        entry.last       = item.frame_end;
        entry.recognized = (count == FRAME_PULSES);

        if (item.frame_end)
        begin
            index_next = 8'd0;
            held_next  = 8'd0;
        end
        else
        begin
            index_next = count;
            held_next  = even ? held_reg : item.pulse_len;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            thresh_reg <= THRESH_RESET;
            index_reg  <= 8'd0;
            held_reg   <= 8'd0;
        end
        else
        begin
            if (cfg_wr)
            begin
                thresh_reg <= cfg_data;
            end
            if (accept)
            begin
                index_reg <= index_next;
                held_reg  <= held_next;
            end
        end
    end

endmodule

@@ rtl/rfpd_queue.sv @@
`include "rf_pulse_frame_decoder_core_defines.svh"

module rfpd_queue
#(
    parameter int DEPTH = rfpd_pkg::QUEUE_DEPTH_DEF
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    input  rfpd_pkg::q_entry_t push_data,
    output logic               full,
    input  logic               pop,
    output rfpd_pkg::q_entry_t pop_data,
    output logic               empty
);
    import rfpd_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(DEPTH);
    localparam logic [PTR_W-1:0] LAST_PTR  = PTR_W'(DEPTH - 1);

    q_entry_t         mem [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;

    assign full     = (count_reg == DEPTH_CNT);
    assign empty    = (count_reg == '0);
    assign pop_data = mem[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + CNT_W'(1);
        end
        else if (pop && !push)
        begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + PTR_W'(1);
            end
            if (pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + PTR_W'(1);
            end
            count_reg <= count_next;
        end
    end

    `RFPD_ASSERT_ALWAYS(a_no_overflow, clk, rst_n, !(push && full), "push into full queue")
    `RFPD_ASSERT_ALWAYS(a_no_underflow, clk, rst_n, !(pop && empty), "pop from empty queue")
    `RFPD_ASSERT_NEXT(a_fill_tracks, clk, rst_n, push && !pop, !empty, "queue empty after push")

endmodule

@@ rtl/rfpd_back.sv @@
`include "rf_pulse_frame_decoder_core_defines.svh"

module rfpd_back
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                empty,
    input  rfpd_pkg::q_entry_t  entry,
    output logic                pop,
    output logic                out_valid,
    input  logic                out_ready,
    output rfpd_pkg::out_item_t out_data
);
    import rfpd_pkg::*;

    logic [31:0] addr_reg;
    logic [31:0] addr_next;
    logic [9:0]  cmd_reg;
    logic [9:0]  cmd_next;
    logic [31:0] addr_sum;
    logic        valid_reg;
    out_item_t   result_reg;
    out_item_t   result_next;

    // a frame end needs the output slot, other pulses never wait
    assign pop = !empty && (!entry.last || !valid_reg || out_ready);

    always_comb
    begin
        addr_next = entry.shift_addr ? {addr_reg[30:0], entry.data_bit} : addr_reg;
        cmd_next  = entry.shift_cmd ? {cmd_reg[8:0], entry.data_bit} : cmd_reg;

        // channel lands at bit 6 of the address
        addr_sum = addr_next + {20'd0, cmd_next[5:0], 6'd0};
        addr_sum[ON_BIT] = (cmd_next[9:8] != CMD_OFF);

        if (entry.recognized)
        begin
            result_next.recognized     = 1'b1;
            result_next.switch_on      = addr_sum[ON_BIT];
            result_next.device_address = addr_sum[27:0] & ADDR_MASK;
        end
        else
        begin
            result_next = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            addr_reg  <= '0;
            cmd_reg   <= '0;
            valid_reg <= 1'b0;
        end
        else
        begin
            if (pop)
            begin
                addr_reg <= entry.last ? '0 : addr_next;
                cmd_reg  <= entry.last ? '0 : cmd_next;
            end
            if (pop && entry.last)
            begin
                valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop && entry.last)
        begin
            result_reg <= result_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_data  = result_reg;

    `RFPD_ASSERT_NEXT(a_frame_clears, clk, rst_n, pop && entry.last,
        addr_reg == '0 && cmd_reg == '0, "shift state not cleared after frame end")
    `RFPD_ASSERT_NEXT(a_end_loads, clk, rst_n, pop && entry.last, valid_reg,
        "frame end produced no result")
    `RFPD_ASSERT_ALWAYS(a_no_drop, clk, rst_n,
        !(pop && entry.last && valid_reg && !out_ready), "pending result overwritten")

endmodule

@@ rtl/rf_pulse_frame_decoder_core.sv @@
// Pulse-width frame decoder: takes one pulse duration per transaction and sustains one
// transaction per clock. Each pulse is classified against the threshold in the front
// stage in the cycle it is taken, then passes through a small queue to the back stage,
// which shifts address and command bits and, on the frame end, registers one result.
// With nothing queued ahead of it and the output slot free, a frame-end pulse is pushed
// into the queue and popped at once, which registers its result and offers it. Input is
// held off only when the queue fills, which happens when results back up at the output.
module rf_pulse_frame_decoder_core
#(
    parameter int QUEUE_DEPTH = rfpd_pkg::QUEUE_DEPTH_DEF
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic [7:0]          cfg_data,
    input  logic                in_valid,
    output logic                in_ready,
    input  rfpd_pkg::in_item_t  in_data,
    output logic                out_valid,
    input  logic                out_ready,
    output rfpd_pkg::out_item_t out_data
);
    import rfpd_pkg::*;

    q_entry_t push_entry;
    q_entry_t head_entry;
    logic     accept;
    logic     full;
    logic     empty;
    logic     pop;

    assign cfg_ready = 1'b1;
    assign in_ready  = !full;
    assign accept    = in_valid && !full;

    rfpd_front u_front
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg_wr   (cfg_valid),
        .cfg_data (cfg_data),
        .accept   (accept),
        .item     (in_data),
        .entry    (push_entry)
    );

    rfpd_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (accept),
        .push_data (push_entry),
        .full      (full),
        .pop       (pop),
        .pop_data  (head_entry),
        .empty     (empty)
    );

    rfpd_back u_back
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .empty     (empty),
        .entry     (head_entry),
        .pop       (pop),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

endmodule

@@ tb/tb_rf_pulse_frame_decoder_core.sv @@
`timescale 1ns / 1ps

module tb_rf_pulse_frame_decoder_core;
    import rfpd_pkg::*;

    localparam int unsigned CYCLE_LIMIT      = 2_000_000;
    localparam int unsigned HOLD_OFF_CYCLES  = 200;
    localparam int unsigned SETTLE_CYCLES    = 8;
    localparam int unsigned RANDOM_PULSES    = 750;
    localparam int unsigned FRAMES_PER_PHASE = 2;
    localparam int unsigned ADDR_BITS_LAST   = 85;
    localparam int unsigned CMD_BITS_LAST    = 113;

    logic      clk;
    logic      rst_n;
    logic      cfg_valid;
    logic      cfg_ready;
    logic [7:0] cfg_data;
    logic      in_valid;
    logic      in_ready;
    in_item_t  in_data;
    logic      out_valid;
    logic      out_ready;
    out_item_t out_data;

    // decoder state as seen from the pins
    logic [7:0]  thresh_now;
    logic [7:0]  pulse_count;
    logic [7:0]  held_len;
    logic [31:0] addr_bits;
    logic [9:0]  cmd_bits;
    out_item_t   frame_results_q[$];

    int unsigned errors;
    int unsigned cycle_count;
    int unsigned pulses_sent;
    int unsigned frames_sent;
    int unsigned results_seen;
    int unsigned recognized_seen;
    int unsigned thresh_writes;
    bit          sender_burst;
    bit          hold_off_req;
    bit          hold_active;

    rf_pulse_frame_decoder_core dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    function automatic int unsigned pick_gap();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 85)
            return $urandom_range(1, 2);
        if (r < 97)
            return $urandom_range(3, 8);
        return $urandom_range(15, 40);
    endfunction

    function automatic void clear_frame_state();
        pulse_count = '0;
        held_len    = '0;
        addr_bits   = '0;
        cmd_bits    = '0;
    endfunction

    // advance the decoder state by one pulse, queue the frame result on the end marker
    function automatic void decode_pulse(input logic [7:0] len, input logic last);
        logic [7:0]  n;
        logic [7:0]  first;
        logic        b;
        logic [31:0] sum;
        out_item_t   r;
        n = (pulse_count == INDEX_MAX) ? INDEX_MAX : pulse_count + 8'd1;
        if (n[0])
        begin
            held_len = len;
        end
        else
        begin
            first = n - 8'd1;
            b = (held_len < thresh_now) && (len > thresh_now);
            if (first >= ADDR_FIRST && first <= ADDR_LAST)
                addr_bits = {addr_bits[30:0], b};
            if (first >= CMD_FIRST && first <= CMD_LAST)
                cmd_bits = {cmd_bits[8:0], b};
        end
        pulse_count = n;
        if (last)
        begin
            r = '0;
            if (pulse_count == FRAME_PULSES)
            begin
                sum = addr_bits + {20'd0, cmd_bits[5:0], 6'd0};
                sum[ON_BIT] = (cmd_bits[9:8] != CMD_OFF);
                r.recognized     = 1'b1;
                r.switch_on      = sum[ON_BIT];
                r.device_address = sum[27:0] & ADDR_MASK;
            end
            frame_results_q.push_back(r);
            clear_frame_state();
        end
    endfunction

    task automatic send_pulse(input logic [7:0] len, input logic last);
        int unsigned gap;
        gap = sender_burst ? 0 : pick_gap();
        if (gap != 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= '{pulse_len: len, frame_end: last};
        do @(posedge clk); while (!in_ready);
        pulses_sent++;
        if (last)
            frames_sent++;
        decode_pulse(len, last);
    endtask

    // quiet the input and let every queued frame result come out
    task automatic drain();
        in_valid <= 1'b0;
        while (frame_results_q.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_threshold(input logic [7:0] value);
        drain();
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        thresh_now = value;
        thresh_writes++;
    endtask

    function automatic logic [7:0] short_len();
        return (thresh_now == 8'd0) ? 8'd0 : 8'($urandom_range(0, thresh_now - 1));
    endfunction

    function automatic logic [7:0] long_len();
        return (thresh_now == 8'hFF) ? 8'hFF : 8'($urandom_range(thresh_now + 1, 255));
    endfunction

    // frame built from address and command words, pairs outside both fields random
    task automatic send_frame(input int unsigned npulses, input logic [31:0] addr,
                              input logic [13:0] cmd, input int unsigned noise_pct);
        logic [7:0]  pair_len[2];
        logic        b;
        int unsigned f;
        sender_burst = ($urandom_range(0, 3) == 0);
        for (int unsigned k = 1; k <= npulses; k++)
        begin
            if (k % 2 == 1)
            begin
                f = k;
                if (f >= ADDR_FIRST && f <= ADDR_BITS_LAST)
                    b = addr[31 - (f - ADDR_FIRST) / 2];
                else if (f >= CMD_FIRST && f <= CMD_BITS_LAST)
                    b = cmd[13 - (f - CMD_FIRST) / 2];
                else
                    b = 1'($urandom_range(0, 1));
                if (b)
                begin
                    pair_len[0] = short_len();
                    pair_len[1] = long_len();
                end
                else
                begin
                    case ($urandom_range(0, 3))
                        0: begin pair_len[0] = long_len();  pair_len[1] = 8'($urandom); end
                        1: begin pair_len[0] = short_len(); pair_len[1] = short_len();  end
                        2: begin pair_len[0] = short_len(); pair_len[1] = thresh_now;   end
                        default: begin pair_len[0] = thresh_now; pair_len[1] = long_len(); end
                    endcase
                end
                for (int i = 0; i < 2; i++)
                    if ($urandom_range(0, 99) < noise_pct)
                        pair_len[i] = 8'($urandom);
            end
            send_pulse(pair_len[(k % 2 == 1) ? 0 : 1], k == npulses);
        end
    endtask

    task automatic test_short_frames();
        sender_burst = 1'b0;
        send_pulse(8'd0, 1'b1);
        send_pulse(8'd255, 1'b1);
        send_pulse(8'd9, 1'b0);
        send_pulse(8'd11, 1'b1);
        // unpaired last pulse
        send_pulse(8'd0, 1'b0);
        send_pulse(8'd255, 1'b0);
        send_pulse(8'd128, 1'b1);
        send_pulse(8'd10, 1'b0);
        send_pulse(8'd10, 1'b1);
        send_pulse(8'h55, 1'b0);
        send_pulse(8'hAA, 1'b0);
        send_pulse(8'h7F, 1'b0);
        send_pulse(8'h80, 1'b1);
        drain();
    endtask

    // receiver holds off while tiny frames keep coming, so results back up into the input
    task automatic test_backpressure();
        hold_off_req = 1'b1;
        wait (hold_active);
        sender_burst = 1'b1;
        for (int i = 0; i < 24; i++)
        begin
            if ($urandom_range(0, 1))
                send_pulse(8'($urandom), 1'b0);
            send_pulse(8'($urandom), 1'b1);
        end
        drain();
    endtask

    task automatic test_random_frames();
        logic [7:0]  thresh_set[7];
        logic [31:0] addr;
        logic [13:0] cmd;
        int unsigned npulses;
        int unsigned r;
        int unsigned phase;
        int unsigned base_pulses;
        thresh_set = '{8'd0, 8'd255, 8'd1, 8'd254, 8'd0, THRESH_RESET, 8'd0};
        phase = 0;
        base_pulses = pulses_sent;
        while (pulses_sent - base_pulses < RANDOM_PULSES)
        begin
            // zero entries in the set stand for a random threshold, except the first
            if (phase % 7 == 0 || thresh_set[phase % 7] != 8'd0)
                write_threshold(thresh_set[phase % 7]);
            else
                write_threshold(8'($urandom_range(2, 200)));
            for (int i = 0; i < FRAMES_PER_PHASE && pulses_sent - base_pulses < RANDOM_PULSES;
                 i++)
            begin
                r = $urandom_range(0, 99);
                if (r < 60)
                    npulses = 32'(FRAME_PULSES);
                else if (r < 75)
                    npulses = $urandom_range(1, 40);
                else if (r < 87)
                    npulses = $urandom_range(110, 122);
                else if (r < 93)
                    npulses = $urandom_range(250, 300);
                else
                    npulses = $urandom_range(41, 255);
                case ($urandom_range(0, 3))
                    0: addr = '0;
                    1: addr = '1;
                    2: addr = {20'hFFFFF, 12'($urandom)};
                    default: addr = $urandom;
                endcase
                cmd = 14'($urandom);
                send_frame(npulses, addr, cmd, ($urandom_range(0, 4) == 0) ? 5 : 0);
            end
            phase++;
        end
        drain();
    endtask

    task automatic check_field(input string name, input logic [27:0] want,
                               input logic [27:0] got);
        if (got !== want)
        begin
            $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
            errors++;
        end
    endtask

    always @(posedge clk)
    begin : check_results
        out_item_t want;
        if (rst_n && out_valid && out_ready)
        begin
            results_seen++;
            if (out_data.recognized === 1'b1)
                recognized_seen++;
            if (frame_results_q.size() == 0)
            begin
                $display("%0t: unexpected frame result, expected none, actual %h",
                         $time, out_data);
                errors++;
            end
            else
            begin
                want = frame_results_q.pop_front();
                check_field("recognized", 28'(want.recognized), 28'(out_data.recognized));
                check_field("switch_on", 28'(want.switch_on), 28'(out_data.switch_on));
                check_field("device_address", want.device_address, out_data.device_address);
            end
        end
    end

    initial
    begin : receiver
        int unsigned stall;
        out_ready <= 1'b0;
        wait (rst_n);
        forever
        begin
            @(posedge clk);
            if (hold_off_req)
            begin
                out_ready <= 1'b0;
                hold_active = 1'b1;
                repeat (HOLD_OFF_CYCLES) @(posedge clk);
                hold_active = 1'b0;
                hold_off_req = 1'b0;
            end
            else if ((cycle_count / 128) % 4 == 0)
            begin
                // steady stretch
                out_ready <= 1'b1;
            end
            else
            begin
                stall = pick_gap();
                if (stall == 0)
                begin
                    out_ready <= 1'b1;
                end
                else
                begin
                    out_ready <= 1'b0;
                    repeat (stall) @(posedge clk);
                end
            end
        end
    end

    initial
    begin : watchdog
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("%0t: timeout, %0d frame results still pending", $time,
                 frame_results_q.size());
        $display("tb_rf_pulse_frame_decoder_core failed");
        $finish;
    end

    initial
    begin : main
        errors          = 0;
        pulses_sent     = 0;
        frames_sent     = 0;
        results_seen    = 0;
        recognized_seen = 0;
        thresh_writes   = 0;
        sender_burst    = 1'b0;
        hold_off_req    = 1'b0;
        hold_active     = 1'b0;
        thresh_now      = THRESH_RESET;
        clear_frame_state();
        rst_n     <= 1'b0;
        cfg_valid <= 1'b0;
        cfg_data  <= '0;
        in_valid  <= 1'b0;
        in_data   <= '0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_short_frames();
        test_backpressure();
        test_random_frames();

        repeat (SETTLE_CYCLES) @(posedge clk);
        $display("run covered %0d pulses in %0d frames, %0d results (%0d recognized)",
                 pulses_sent, frames_sent, results_seen, recognized_seen);
        $display("threshold written %0d times, extremes included, one long output hold-off",
                 thresh_writes);
        if (errors == 0)
            $display("tb_rf_pulse_frame_decoder_core passed");
        else
            $display("tb_rf_pulse_frame_decoder_core failed");
        $finish;
    end

endmodule
